FILE: rtl/core/motor_command_frame_to_duty_assert.svh
// assertion macros shared by the motor command frame decoder
`ifndef MOTOR_COMMAND_FRAME_TO_DUTY_ASSERT_SVH
`define MOTOR_COMMAND_FRAME_TO_DUTY_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MCFD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mcfd assertion failed");

// next-cycle implication, disabled during reset
`define MCFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mcfd assertion failed");

`endif

FILE: rtl/core/mcfd_pkg.sv
// types and constants of the motor command frame decoder
package mcfd_pkg;

  localparam int ByteW  = 8;
  localparam int RawW   = 16;
  localparam int SpW    = 15;
  localparam int MagW   = 14;
  localparam int PwmW   = 16;
  localparam int DutyW  = 16;

  localparam int DutyBitsDef = 16;

  localparam logic [ByteW-1:0] HdrByte = 8'hFF;
  localparam logic [ByteW-1:0] IdOne   = 8'hFA;
  localparam logic [ByteW-1:0] IdTwo   = 8'hFB;

  localparam int SpScale = 10000;
  localparam int SpHalf  = 5000;

  localparam logic signed [RawW-1:0] SpMaxRaw = 16'sd10000;
  localparam logic signed [RawW-1:0] SpMinRaw = -16'sd10000;
  localparam logic signed [SpW-1:0]  SpMaxOut = 15'sd10000;
  localparam logic signed [SpW-1:0]  SpMinOut = -15'sd10000;

  localparam logic [PwmW-1:0] PwmMaxRst = 16'hFFFF;

  typedef enum logic [3:0] {
    PhHeader = 4'b0001,
    PhId     = 4'b0010,
    PhHigh   = 4'b0100,
    PhLow    = 4'b1000
  } phase_e;

  typedef struct packed {
    logic            motor;
    logic [RawW-1:0] raw;
  } frame_t;

endpackage

FILE: rtl/core/mcfd_if.sv
// channel interfaces: received bytes, pwm limit writes, duty results
interface mcfd_rx_if;
  import mcfd_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mcfd_cfg_if;
  import mcfd_pkg::*;
  logic            valid;
  logic            ready;
  logic [PwmW-1:0] pwm_max;
  modport source (output valid, output pwm_max, input ready);
  modport sink (input valid, input pwm_max, output ready);
endinterface

interface mcfd_duty_if;
  import mcfd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  motor_select;
  logic signed [SpW-1:0] setpoint_hundredths;
  logic [DutyW-1:0]      duty_forward;
  logic [DutyW-1:0]      duty_reverse;
  modport source (output valid, output motor_select, output setpoint_hundredths,
                  output duty_forward, output duty_reverse, input ready);
  modport sink (input valid, input motor_select, input setpoint_hundredths,
                input duty_forward, input duty_reverse, output ready);
endinterface

FILE: rtl/core/mcfd_parser.sv
// byte-wise frame parser: header, motor id, setpoint high and low byte
module mcfd_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      take_i,
  input  logic [mcfd_pkg::ByteW-1:0] byte_i,
  output logic                      frame_valid_o,
  output mcfd_pkg::frame_t          frame_o
);
  import mcfd_pkg::*;

  phase_e           phase_q, phase_d;
  logic             motor_q, motor_d;
  logic [ByteW-1:0] high_q, high_d;

  always_comb begin
    phase_d       = phase_q;
    motor_d       = motor_q;
    high_d        = high_q;
    frame_valid_o = 1'b0;
    if (take_i) begin
      unique case (phase_q)
        PhHeader: begin
          if (byte_i == HdrByte) phase_d = PhId;
        end
        PhId: begin
          if (byte_i == IdOne || byte_i == IdTwo) begin
            motor_d = (byte_i == IdTwo);
            phase_d = PhHigh;
          end else begin
            phase_d = PhHeader;
          end
        end
        PhHigh: begin
          high_d  = byte_i;
          phase_d = PhLow;
        end
        PhLow: begin
          frame_valid_o = 1'b1;
          phase_d       = PhHeader;
        end
        default: phase_d = PhHeader;
      endcase
    end
  end

  assign frame_o.motor = motor_q;
  assign frame_o.raw   = {high_q, byte_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      motor_q <= 1'b0;
      high_q  <= '0;
    end else begin
      phase_q <= phase_d;
      motor_q <= motor_d;
      high_q  <= high_d;
    end
  end

endmodule

FILE: rtl/core/mcfd_duty.sv
// four-stage duty pipeline: frame, clamp, scale by pwm limit, divide by 10000
module mcfd_duty #(
  parameter int DUTY_BITS = mcfd_pkg::DutyBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      frame_valid_i,
  output logic                      frame_ready_o,
  input  mcfd_pkg::frame_t          frame_i,
  input  logic [mcfd_pkg::PwmW-1:0] pwm_max_i,
  mcfd_duty_if.source               duty_o
);
  import mcfd_pkg::*;

  localparam int NumW   = MagW + DUTY_BITS;
  localparam int Shift  = NumW + MagW;
  localparam int RecipW = NumW + 1;
  localparam int ProdW  = NumW + RecipW;
  localparam logic [63:0] RecipFull =
    ((64'd1 << Shift) + 64'(SpScale - 1)) / 64'(SpScale);
  localparam logic [RecipW-1:0] Recip = RecipFull[RecipW-1:0];

  logic en1, en2, en3, en4;

  // stage 1: captured frame
  logic   v1_q;
  frame_t f1_q;

  // stage 2: clamped setpoint and magnitude
  logic                  v2_q, m2_q, n2_q;
  logic signed [SpW-1:0] sp2_q;
  logic [MagW-1:0]       mag2_q;

  // stage 3: rounded product
  logic                  v3_q, m3_q, n3_q;
  logic signed [SpW-1:0] sp3_q;
  logic [NumW-1:0]       num3_q;

  // stage 4: result register
  logic                  v4_q, m4_q;
  logic signed [SpW-1:0] sp4_q;
  logic [DutyW-1:0]      fwd4_q, rev4_q;

  logic signed [RawW-1:0] raw_s, sp_c, mag_c;
  logic [DUTY_BITS-1:0]   lim;
  logic [NumW-1:0]        num_d;
  logic [ProdW-1:0]       quo_full;
  logic [DUTY_BITS-1:0]   quo;

  assign en4 = !v4_q || duty_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign frame_ready_o = en1;

  always_comb begin
    raw_s = $signed(f1_q.raw);
    if (raw_s > SpMaxRaw) begin
      sp_c = SpMaxRaw;
    end else if (raw_s < SpMinRaw) begin
      sp_c = SpMinRaw;
    end else begin
      sp_c = raw_s;
    end
    mag_c = sp_c[RawW-1] ? -sp_c : sp_c;
  end

  assign lim = (pwm_max_i > PwmW'({DUTY_BITS{1'b1}})) ? {DUTY_BITS{1'b1}}
                                                       : pwm_max_i[DUTY_BITS-1:0];
  assign num_d    = NumW'(mag2_q) * NumW'(lim) + NumW'(SpHalf);
  assign quo_full = ProdW'(num3_q) * ProdW'(Recip);
  assign quo      = quo_full[Shift +: DUTY_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= frame_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && frame_valid_i) begin
      f1_q <= frame_i;
    end
    if (en2 && v1_q) begin
      m2_q   <= f1_q.motor;
      n2_q   <= sp_c[RawW-1];
      sp2_q  <= sp_c[SpW-1:0];
      mag2_q <= mag_c[MagW-1:0];
    end
    if (en3 && v2_q) begin
      m3_q   <= m2_q;
      n3_q   <= n2_q;
      sp3_q  <= sp2_q;
      num3_q <= num_d;
    end
    if (en4 && v3_q) begin
      m4_q   <= m3_q;
      sp4_q  <= sp3_q;
      fwd4_q <= n3_q ? '0 : DutyW'(quo);
      rev4_q <= n3_q ? DutyW'(quo) : '0;
    end
  end

  assign duty_o.valid               = v4_q;
  assign duty_o.motor_select        = m4_q;
  assign duty_o.setpoint_hundredths = sp4_q;
  assign duty_o.duty_forward        = fwd4_q;
  assign duty_o.duty_reverse        = rev4_q;

endmodule

FILE: rtl/core/motor_command_frame_to_duty.sv
// motor command frame decoder top level
// rx_i takes one received byte per beat and is ready whenever the first
// pipeline stage is free, so bytes stream in at one per cycle unless a stall on duty_o has filled every stage.
// frames are 0xFF, motor id 0xFA or 0xFB, setpoint high byte, low byte;
// a bad id drops the parser back to header search.
// only the low byte of a frame yields a beat on duty_o: motor, setpoint
// clamped to +/-10000 and duty = (|setpoint| * pwm_max + 5000) / 10000,
// placed on duty_forward or duty_reverse by sign.
// the low byte is registered in the frame stage and passes the clamp, multiply
// and reciprocal-multiply stages before the result is valid on duty_o.
// one byte is taken per cycle while rx_i is ready; the pipeline holds up to four results.
// cfg_i is always ready and writes pwm_max (reset 65535), limited to the
// duty width; write it only while the block is idle.
// a stall on duty_o holds the result and fills bubbles behind it; rx_i
// stalls only once every stage holds a result.
// reset clears the parser to header search and empties the pipeline.
`include "motor_command_frame_to_duty_assert.svh"
module motor_command_frame_to_duty #(
  parameter int DUTY_BITS = mcfd_pkg::DutyBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mcfd_rx_if.sink     rx_i,
  mcfd_cfg_if.sink    cfg_i,
  mcfd_duty_if.source duty_o
);
  import mcfd_pkg::*;

  logic            cfg_write;
  logic [PwmW-1:0] pwm_q;
  logic            take;
  logic            frame_valid;
  logic            frame_ready;
  frame_t          frame;

  assign cfg_write   = cfg_i.valid;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_q <= PwmMaxRst;
    end else if (cfg_write) begin
      pwm_q <= cfg_i.pwm_max;
    end
  end

  assign rx_i.ready = frame_ready;
  assign take       = rx_i.valid && frame_ready;

  mcfd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .byte_i        (rx_i.rx_byte),
    .frame_valid_o (frame_valid),
    .frame_o       (frame)
  );

  mcfd_duty #(
    .DUTY_BITS (DUTY_BITS)
  ) u_duty (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (frame_valid),
    .frame_ready_o (frame_ready),
    .frame_i       (frame),
    .pwm_max_i     (pwm_q),
    .duty_o        (duty_o)
  );

  `MCFD_ASSERT_NOW(a_sp_range, duty_o.valid,
    duty_o.setpoint_hundredths <= SpMaxOut && duty_o.setpoint_hundredths >= SpMinOut)
  `MCFD_ASSERT_NOW(a_one_side, duty_o.valid,
    duty_o.duty_forward == '0 || duty_o.duty_reverse == '0)
  `MCFD_ASSERT_NOW(a_neg_fwd_zero, duty_o.valid && duty_o.setpoint_hundredths[SpW-1],
    duty_o.duty_forward == '0)
  `MCFD_ASSERT_NEXT(a_cfg_taken, cfg_i.valid, pwm_q == $past(cfg_i.pwm_max))

endmodule

FILE: dv/motor_command_frame_to_duty_checker.sv
// duty result checker: predicts each frame's result from the byte stream and compares
module mcfd_duty_checker
  import mcfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mcfd_rx_if          rx_i,
  mcfd_cfg_if         cfg_i,
  mcfd_duty_if        duty_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                  motor;
    logic signed [SpW-1:0] setpoint;
    logic [DutyW-1:0]      fwd;
    logic [DutyW-1:0]      rev;
  } duty_beat_t;

  localparam int unsigned DutyTop = (1 << DutyBitsDef) - 1;

  duty_beat_t       duty_expected_q[$];
  phase_e           parse_phase;
  logic             held_motor;
  logic [ByteW-1:0] held_high;
  logic [PwmW-1:0]  pwm_max_q;

  task automatic decode_byte(input logic [ByteW-1:0] b);
    logic signed [RawW-1:0] raw;
    int                     sp;
    int unsigned            mag;
    int unsigned            lim;
    int unsigned            duty;
    duty_beat_t             beat;
    case (parse_phase)
      PhHeader: begin
        if (b == HdrByte) parse_phase = PhId;
      end
      PhId: begin
        if (b == IdOne || b == IdTwo) begin
          held_motor  = (b == IdTwo);
          parse_phase = PhHigh;
        end else begin
          parse_phase = PhHeader;
        end
      end
      PhHigh: begin
        held_high   = b;
        parse_phase = PhLow;
      end
      default: begin
        raw = {held_high, b};
        sp  = int'(raw);
        if (sp > int'(SpMaxRaw)) sp = int'(SpMaxRaw);
        if (sp < int'(SpMinRaw)) sp = int'(SpMinRaw);
        mag  = (sp < 0) ? -sp : sp;
        lim  = (pwm_max_q > DutyTop) ? DutyTop : pwm_max_q;
        duty = (mag * lim + SpHalf) / SpScale;
        beat.motor    = held_motor;
        beat.setpoint = sp[SpW-1:0];
        beat.fwd      = (sp >= 0) ? duty[DutyW-1:0] : '0;
        beat.rev      = (sp < 0) ? duty[DutyW-1:0] : '0;
        duty_expected_q.push_back(beat);
        parse_phase = PhHeader;
      end
    endcase
  endtask

  task automatic check_duty_beat();
    duty_beat_t want;
    if (duty_expected_q.size() == 0) begin
      $error("unexpected duty beat: motor_select %0d setpoint_hundredths %0d",
             duty_i.motor_select, duty_i.setpoint_hundredths);
      fail_count_o++;
    end else begin
      want = duty_expected_q.pop_front();
      if (duty_i.motor_select !== want.motor) begin
        $error("motor_select expected %0d actual %0d", want.motor, duty_i.motor_select);
        fail_count_o++;
      end
      if (duty_i.setpoint_hundredths !== want.setpoint) begin
        $error("setpoint_hundredths expected %0d actual %0d",
               want.setpoint, duty_i.setpoint_hundredths);
        fail_count_o++;
      end
      if (duty_i.duty_forward !== want.fwd) begin
        $error("duty_forward expected %0d actual %0d", want.fwd, duty_i.duty_forward);
        fail_count_o++;
      end
      if (duty_i.duty_reverse !== want.rev) begin
        $error("duty_reverse expected %0d actual %0d", want.rev, duty_i.duty_reverse);
        fail_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_phase = PhHeader;
      held_motor  = 1'b0;
      held_high   = '0;
      pwm_max_q   = PwmMaxRst;
      fail_count_o = 0;
      duty_expected_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) pwm_max_q = cfg_i.pwm_max;
      if (duty_i.valid && duty_i.ready) check_duty_beat();
      if (rx_i.valid && rx_i.ready) decode_byte(rx_i.rx_byte);
      pending_o <= duty_expected_q.size();
    end
  end

endmodule

FILE: dv/testbench.sv
// testbench top: byte and pwm limit stimulus, result backpressure, watchdog and verdict
module testbench;
  import mcfd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam time         ClkPeriod   = 20ns;
  localparam int          Segments    = 8;
  localparam int          SegBytes    = 225;
  localparam int          SettleWait  = 8;
  localparam int          DrainCycles = 16;
  localparam int unsigned QuietLimit  = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int          gap_pct;
  int          stall_pct;
  int unsigned quiet_cycles;

  mcfd_rx_if   rx_if ();
  mcfd_cfg_if  cfg_if ();
  mcfd_duty_if duty_if ();

  motor_command_frame_to_duty dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .cfg_i  (cfg_if),
    .duty_o (duty_if)
  );

  mcfd_duty_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_if),
    .cfg_i        (cfg_if),
    .duty_i       (duty_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  task automatic send_byte(input logic [ByteW-1:0] b);
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  task automatic write_pwm_max(input logic [PwmW-1:0] value);
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleWait) @(posedge clk_i);
    cfg_if.valid   <= 1'b1;
    cfg_if.pwm_max <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_frame(input logic id_two, input logic [RawW-1:0] sp);
    send_byte(HdrByte);
    send_byte(id_two ? IdTwo : IdOne);
    send_byte(sp[15:8]);
    send_byte(sp[7:0]);
  endtask

  task automatic send_random_bytes(input int count);
    int               sent;
    int               pick;
    int               mag;
    logic [RawW-1:0]  sp;
    logic [ByteW-1:0] bad_id;
    sent = 0;
    while (sent < count) begin
      pick = int'($urandom_range(99));
      if (pick < 75) begin
        case ($urandom_range(9))
          0, 1, 2, 3: sp = 16'($urandom_range(16'hFFFF));
          4: begin
            mag = 9999 + int'($urandom_range(2));
            sp  = $urandom_range(1) ? 16'(-mag) : 16'(mag);
          end
          5: sp = '0;
          6: sp = $urandom_range(1) ? 16'h7FFF : 16'h8000;
          7: begin
            mag = int'($urandom_range(200));
            sp  = $urandom_range(1) ? 16'(-mag) : 16'(mag);
          end
          8: sp = $urandom_range(1) ? {8'hFF, 8'($urandom_range(255))}
                                    : {8'($urandom_range(255)), 8'hFF};
          default: begin
            mag = int'($urandom_range(10000));
            sp  = $urandom_range(1) ? 16'(-mag) : 16'(mag);
          end
        endcase
        send_frame(1'($urandom_range(1)), sp);
        sent += 4;
      end else if (pick < 88) begin
        if ($urandom_range(2) == 0) begin
          bad_id = HdrByte;
        end else begin
          do bad_id = 8'($urandom_range(255)); while (bad_id == IdOne || bad_id == IdTwo);
        end
        send_byte(HdrByte);
        send_byte(bad_id);
        send_byte(8'($urandom_range(255)));
        sent += 3;
      end else begin
        repeat ($urandom_range(3, 1)) begin
          send_byte(8'($urandom_range(255)));
          sent++;
        end
      end
    end
    rx_if.valid <= 1'b0;
  endtask

  initial begin
    duty_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      duty_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk_i);
      if ((rx_if.valid && rx_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (duty_if.valid && duty_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [PwmW-1:0] pwm_settings[Segments];
    pwm_settings = '{16'd1, 16'hFFFF, 16'd0, 16'($urandom_range(16'hFFFF)),
                     16'd10000, 16'($urandom_range(16'hFFFF)), 16'h8000,
                     16'($urandom_range(16'hFFFF))};
    gap_pct        = 0;
    stall_pct      = 0;
    rst_ni         <= 1'b0;
    rx_if.valid    <= 1'b0;
    rx_if.rx_byte  <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.pwm_max <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // clamp edges, zero, payload bytes of 0xff, bad ids
    send_frame(1'b0, 16'd10000);
    send_frame(1'b1, -16'sd10000);
    send_frame(1'b0, 16'h7FFF);
    send_frame(1'b1, 16'h8000);
    send_frame(1'b0, 16'h0000);
    send_frame(1'b1, 16'hFFFF);
    send_byte(HdrByte);
    send_byte(HdrByte);
    send_byte(IdOne);
    send_byte(8'h00);
    send_byte(HdrByte);
    send_byte(8'h00);
    send_frame(1'b1, 16'h00FF);
    rx_if.valid <= 1'b0;

    for (int seg = 0; seg < Segments; seg++) begin
      case (seg % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 53; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 53; end
        default: begin gap_pct = 37; stall_pct = 37; end
      endcase
      write_pwm_max(pwm_settings[seg]);
      send_random_bytes(SegBytes);
    end

    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
